### design/rbsm_pkg.sv
// Shared types, command codes and arithmetic helpers for the servo mixer.
`default_nettype none
package rbsm_pkg;

    localparam logic [1:0] CMD_RULE   = 2'd0;
    localparam logic [1:0] CMD_SERVO  = 2'd1;
    localparam logic [1:0] CMD_SOURCE = 2'd2;
    localparam logic [1:0] CMD_TICK   = 2'd3;

    // floor(x * RECIP_100 / 2**31) equals floor(x / 100) for every x below 2**24.
    localparam logic [24:0] RECIP_100 = 25'd21474837;

    typedef struct packed {
        logic [2:0]         target;
        logic [3:0]         source;
        logic signed [7:0]  rate;
        logic [7:0]         speed;
        logic [11:0]        lo_pct;
        logic [11:0]        hi_pct;
        logic [3:0]         box;
    } rule_t;

    typedef struct packed {
        logic [11:0]        min_p;
        logic [11:0]        max_p;
        logic signed [15:0] middle;
        logic signed [7:0]  rate;
        logic [15:0]        rev;
    } servo_t;

    typedef struct packed {
        logic       tick_clear;
        logic       rule_rd;
        logic       rule_fetch;
        logic       rule_eval;
        logic       issue_hi;
        logic       issue_c;
        logic       take_lo;
        logic       take_hi;
        logic       rule_add;
        logic       servo_rd;
        logic       servo_issue;
        logic       servo_emit;
        logic       servo_phase;
        logic       last;
        logic [5:0] rule_idx;
        logic [2:0] servo_idx;
    } ctrl_cmd_t;

    typedef struct packed {
        logic rule_skip;
    } dp_status_t;

    function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
        logic signed [15:0] r;
        if (v > 20'sd32767)
        begin
            r = 16'sh7fff;
        end
        else if (v < -20'sd32768)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### design/rule_based_servo_mixer.sv
// Top level of the rule-based servo mixer: controller and datapath.
// Write commands leave busy low, and the next command may follow at once.
// A mix tick takes each rule in use through read, fetch, evaluate, multiply, add (a rule
// that is disabled or drives no servo stops after evaluate), then each reported servo
// through read, multiply, emit; the receiver cannot stall, busy falls with the last one.
// Reset clears sources, running outputs, servo sums and the rule count.
`default_nettype none
module rule_based_servo_mixer
    import rbsm_pkg::*;
#(
    parameter int RULES   = 16,
    parameter int SERVOS  = 8,
    parameter int SOURCES = 16
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               rule_count_we,
    input  wire logic [4:0]         rule_count,
    input  wire logic [1:0]         command,
    input  wire logic [3:0]         index,
    input  wire logic signed [15:0] value,
    input  wire logic [2:0]         rule_target,
    input  wire logic [3:0]         rule_source,
    input  wire logic signed [7:0]  scale,
    input  wire logic [7:0]         rule_speed,
    input  wire logic [11:0]        low_bound,
    input  wire logic [11:0]        high_bound,
    input  wire logic [3:0]         rule_box,
    input  wire logic [15:0]        bit_mask,
    output logic                    strobe,
    output logic [2:0]              servo_index,
    output logic signed [15:0]      servo_pulse,
    output logic                    last
);

    ctrl_cmd_t  cmd;
    dp_status_t status;
    logic       accept;

    assign accept = start && !busy;

    rbsm_ctrl #(
        .RULES  (RULES),
        .SERVOS (SERVOS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .command       (command),
        .rule_count_we (rule_count_we),
        .rule_count    (rule_count),
        .status        (status),
        .cmd           (cmd),
        .busy          (busy)
    );

    rbsm_dpath #(
        .RULES   (RULES),
        .SERVOS  (SERVOS),
        .SOURCES (SOURCES)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .command     (command),
        .index       (index),
        .value       (value),
        .rule_target (rule_target),
        .rule_source (rule_source),
        .scale       (scale),
        .rule_speed  (rule_speed),
        .low_bound   (low_bound),
        .high_bound  (high_bound),
        .rule_box    (rule_box),
        .bit_mask    (bit_mask),
        .cmd         (cmd),
        .status      (status),
        .strobe      (strobe),
        .servo_index (servo_index),
        .servo_pulse (servo_pulse),
        .last        (last)
    );

endmodule
`default_nettype wire

### design/rbsm_div100.sv
// Shared multiply unit whose product is divided by 100, truncating toward zero.
`default_nettype none
module rbsm_div100
    import rbsm_pkg::*;
(
    input  wire logic               clk,
    input  wire logic signed [16:0] a,
    input  wire logic signed [12:0] b,
    output logic signed [18:0]      q
);

    logic signed [29:0] prod_reg;
    logic signed [18:0] q_reg;
    logic [29:0]        mag;
    logic [48:0]        full;
    logic [17:0]        qm;
    logic signed [18:0] q_next;

    always_comb
    begin
        mag    = prod_reg[29] ? 30'(-prod_reg) : 30'(prod_reg);
        full   = 49'(mag[23:0]) * 49'(RECIP_100);
        qm     = full[48:31];
        q_next = prod_reg[29] ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 30'(a) * 30'(b);
        q_reg    <= q_next;
    end

    assign q = q_reg;

endmodule
`default_nettype wire

### design/rbsm_ctrl.sv
// Controller that sequences a mix tick over the rules and then the servos.
`default_nettype none
module rbsm_ctrl
    import rbsm_pkg::*;
#(
    parameter int RULES  = 16,
    parameter int SERVOS = 8
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic [1:0] command,
    input  wire logic       rule_count_we,
    input  wire logic [4:0] rule_count,
    input  wire dp_status_t status,
    output ctrl_cmd_t       cmd,
    output logic            busy
);

    localparam int NOUT = (SERVOS < 8) ? SERVOS : 8;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_R0   = 4'd1;
    localparam logic [3:0] S_R1   = 4'd2;
    localparam logic [3:0] S_R2   = 4'd3;
    localparam logic [3:0] S_R3   = 4'd4;
    localparam logic [3:0] S_R4   = 4'd5;
    localparam logic [3:0] S_R5   = 4'd6;
    localparam logic [3:0] S_R6   = 4'd7;
    localparam logic [3:0] S_V0   = 4'd8;
    localparam logic [3:0] S_V1   = 4'd9;
    localparam logic [3:0] S_V2   = 4'd10;
    localparam logic [3:0] S_V3   = 4'd11;

    logic [3:0] state_reg, state_next;
    logic [5:0] rule_idx_reg, rule_idx_next;
    logic [2:0] servo_idx_reg, servo_idx_next;
    logic [4:0] count_reg;
    logic [6:0] count_ext;
    logic [6:0] limit;
    logic       last_rule;
    logic       last_servo;

    always_comb
    begin
        count_ext  = {2'b00, count_reg};
        limit      = (count_ext > 7'(RULES)) ? 7'(RULES) : count_ext;
        last_rule  = (7'({1'b0, rule_idx_reg}) + 7'd1) == limit;
        last_servo = servo_idx_reg == 3'(NOUT - 1);
    end

    always_comb
    begin
        cmd            = '0;
        cmd.rule_idx   = rule_idx_reg;
        cmd.servo_idx  = servo_idx_reg;
        cmd.last       = last_servo;
        state_next     = state_reg;
        rule_idx_next  = rule_idx_reg;
        servo_idx_next = servo_idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start && (command == CMD_TICK))
                begin
                    cmd.tick_clear = 1'b1;
                    rule_idx_next  = '0;
                    servo_idx_next = '0;
                    state_next     = (limit == 7'd0) ? S_V0 : S_R0;
                end
            end
            S_R0:
            begin
                cmd.rule_rd = 1'b1;
                state_next  = S_R1;
            end
            S_R1:
            begin
                cmd.rule_fetch = 1'b1;
                state_next     = S_R2;
            end
            S_R2:
            begin
                cmd.rule_eval = 1'b1;
                if (status.rule_skip)
                begin
                    state_next    = last_rule ? S_V0 : S_R0;
                    rule_idx_next = rule_idx_reg + 6'd1;
                end
                else
                begin
                    state_next = S_R3;
                end
            end
            S_R3:
            begin
                cmd.issue_hi = 1'b1;
                state_next   = S_R4;
            end
            S_R4:
            begin
                cmd.issue_c = 1'b1;
                cmd.take_lo = 1'b1;
                state_next  = S_R5;
            end
            S_R5:
            begin
                cmd.take_hi = 1'b1;
                state_next  = S_R6;
            end
            S_R6:
            begin
                cmd.rule_add  = 1'b1;
                state_next    = last_rule ? S_V0 : S_R0;
                rule_idx_next = rule_idx_reg + 6'd1;
            end
            S_V0:
            begin
                cmd.servo_rd    = 1'b1;
                cmd.servo_phase = 1'b1;
                state_next      = S_V1;
            end
            S_V1:
            begin
                cmd.servo_issue = 1'b1;
                cmd.servo_phase = 1'b1;
                state_next      = S_V2;
            end
            S_V2:
            begin
                cmd.servo_phase = 1'b1;
                state_next      = S_V3;
            end
            S_V3:
            begin
                cmd.servo_emit  = 1'b1;
                cmd.servo_phase = 1'b1;
                state_next      = last_servo ? S_IDLE : S_V0;
                servo_idx_next  = servo_idx_reg + 3'd1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rule_idx_reg  <= '0;
            servo_idx_reg <= '0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rule_idx_reg  <= rule_idx_next;
            servo_idx_reg <= servo_idx_next;
            if (rule_count_we)
            begin
                count_reg <= rule_count;
            end
        end
    end

    assign busy = state_reg != S_IDLE;

endmodule
`default_nettype wire

### design/rbsm_dpath.sv
// Datapath with the rule, servo and source stores and the mixing arithmetic.
`default_nettype none
module rbsm_dpath
    import rbsm_pkg::*;
#(
    parameter int RULES   = 16,
    parameter int SERVOS  = 8,
    parameter int SOURCES = 16
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               accept,
    input  wire logic [1:0]         command,
    input  wire logic [3:0]         index,
    input  wire logic signed [15:0] value,
    input  wire logic [2:0]         rule_target,
    input  wire logic [3:0]         rule_source,
    input  wire logic signed [7:0]  scale,
    input  wire logic [7:0]         rule_speed,
    input  wire logic [11:0]        low_bound,
    input  wire logic [11:0]        high_bound,
    input  wire logic [3:0]         rule_box,
    input  wire logic [15:0]        bit_mask,
    input  wire ctrl_cmd_t          cmd,
    output dp_status_t              status,
    output logic                    strobe,
    output logic [2:0]              servo_index,
    output logic signed [15:0]      servo_pulse,
    output logic                    last
);

    localparam int RW = (RULES > 1) ? $clog2(RULES) : 1;
    localparam int SW = (SERVOS > 1) ? $clog2(SERVOS) : 1;
    localparam int CW = (SOURCES > 1) ? $clog2(SOURCES) : 1;

    rule_t              rule_mem [RULES];
    logic signed [15:0] rout_mem [RULES];
    servo_t             servo_mem [SERVOS];
    logic [RULES-1:0]   rout_vld_reg;
    logic signed [15:0] src_reg [SOURCES];
    logic signed [15:0] sum_reg [SERVOS];

    rule_t              rule_q;
    logic signed [15:0] rout_q;
    logic               rout_vld_q;
    servo_t             servo_q;
    logic signed [15:0] srcv_q;
    logic [15:0]        box_mask_q;
    logic signed [15:0] cur_q;
    logic [11:0]        span_q;
    logic signed [15:0] lo_q;
    logic signed [15:0] hi_q;

    logic               strobe_reg;
    logic [2:0]         index_reg;
    logic signed [15:0] pulse_reg;
    logic               last_reg;

    logic [6:0]         idx_ext;
    logic [RW-1:0]      rule_addr;
    logic [4:0]         servo_addr_ext;
    logic [SW-1:0]      servo_addr;
    logic [4:0]         src_ext;
    logic               src_ok;
    logic               target_ok;
    logic               active;
    logic signed [17:0] cur0;
    logic signed [17:0] srcw;
    logic signed [17:0] up;
    logic signed [17:0] dn;
    logic signed [17:0] cur_new;
    logic [11:0]        span_now;
    logic signed [16:0] mul_a;
    logic signed [12:0] mul_b;
    logic signed [18:0] quot;
    logic signed [19:0] quot_w;
    logic signed [15:0] sum_rd;
    logic signed [19:0] lo_w;
    logic signed [19:0] hi_w;
    logic signed [19:0] c_clamped;
    logic signed [15:0] c_sign;
    logic signed [15:0] sum_new;
    logic signed [15:0] v1;
    logic signed [15:0] v2;
    logic signed [19:0] vmin;
    logic signed [19:0] vmax;
    logic signed [15:0] pulse_next;

    always_comb
    begin
        idx_ext        = {3'b000, index};
        rule_addr      = cmd.rule_idx[RW-1:0];
        servo_addr_ext = cmd.servo_phase ? {2'b00, cmd.servo_idx} : {2'b00, rule_q.target};
        servo_addr     = servo_addr_ext[SW-1:0];
        src_ext        = {1'b0, rule_q.source};
        src_ok         = 6'({1'b0, src_ext}) < 6'(SOURCES);
        target_ok      = 6'({3'b000, rule_q.target}) < 6'(SERVOS);
        sum_rd         = sum_reg[servo_addr];

        active = (rule_q.box == 4'd0) || box_mask_q[4'(rule_q.box - 4'd1)];
        cur0   = rout_vld_q ? 18'(rout_q) : 18'sd0;
        srcw   = 18'(srcv_q);
        up     = cur0 + $signed({10'b0, rule_q.speed});
        dn     = cur0 - $signed({10'b0, rule_q.speed});
        if (rule_q.speed == 8'd0)
        begin
            cur_new = srcw;
        end
        else if (cur0 < srcw)
        begin
            cur_new = (up > srcw) ? srcw : up;
        end
        else if (cur0 > srcw)
        begin
            cur_new = (dn < srcw) ? srcw : dn;
        end
        else
        begin
            cur_new = cur0;
        end
        status.rule_skip = !active || !target_ok;
        span_now = (servo_q.max_p > servo_q.min_p) ? 12'(servo_q.max_p - servo_q.min_p) : 12'd0;

        if (cmd.servo_issue)
        begin
            mul_a = 17'(sum_rd);
            mul_b = 13'(servo_q.rate);
        end
        else if (cmd.issue_c)
        begin
            mul_a = 17'(cur_q);
            mul_b = 13'(rule_q.rate);
        end
        else if (cmd.issue_hi)
        begin
            mul_a = $signed({5'b0, rule_q.hi_pct});
            mul_b = $signed({1'b0, span_q});
        end
        else
        begin
            mul_a = $signed({5'b0, rule_q.lo_pct});
            mul_b = $signed({1'b0, span_now});
        end

        quot_w = 20'(quot);
        lo_w   = 20'(lo_q);
        hi_w   = 20'(hi_q);
        if (quot_w < lo_w)
        begin
            c_clamped = lo_w;
        end
        else if (quot_w > hi_w)
        begin
            c_clamped = hi_w;
        end
        else
        begin
            c_clamped = quot_w;
        end
        if (servo_q.rev[rule_q.source])
        begin
            c_sign = (c_clamped[15:0] == 16'sh8000) ? 16'sh7fff : -c_clamped[15:0];
        end
        else
        begin
            c_sign = c_clamped[15:0];
        end
        sum_new = sat16(20'(sum_rd) + 20'(c_sign));

        v1   = sat16(quot_w);
        v2   = sat16(20'(v1) + 20'(servo_q.middle));
        vmin = $signed({8'b0, servo_q.min_p});
        vmax = $signed({8'b0, servo_q.max_p});
        if (20'(v2) < vmin)
        begin
            pulse_next = vmin[15:0];
        end
        else if (20'(v2) > vmax)
        begin
            pulse_next = vmax[15:0];
        end
        else
        begin
            pulse_next = v2;
        end
    end

    rbsm_div100 u_div100
    (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .q   (quot)
    );

    always_ff @(posedge clk)
    begin
        if (accept && (command == CMD_RULE) && (idx_ext < 7'(RULES)))
        begin
            rule_mem[idx_ext[RW-1:0]] <= '{target: rule_target, source: rule_source,
                                          rate: scale, speed: rule_speed,
                                          lo_pct: low_bound, hi_pct: high_bound,
                                          box: rule_box};
        end
        if (accept && (command == CMD_SERVO) && (idx_ext < 7'(SERVOS)))
        begin
            servo_mem[idx_ext[SW-1:0]] <= '{min_p: low_bound, max_p: high_bound,
                                            middle: value, rate: scale, rev: bit_mask};
        end
        if (cmd.rule_rd)
        begin
            rule_q     <= rule_mem[rule_addr];
            rout_q     <= rout_mem[rule_addr];
            rout_vld_q <= rout_vld_reg[rule_addr];
        end
        if (cmd.rule_fetch || cmd.servo_rd)
        begin
            servo_q <= servo_mem[servo_addr];
        end
        if (cmd.rule_fetch)
        begin
            srcv_q <= src_ok ? src_reg[src_ext[CW-1:0]] : 16'sd0;
        end
        if (cmd.rule_eval)
        begin
            rout_mem[rule_addr] <= active ? cur_new[15:0] : 16'sd0;
            cur_q               <= cur_new[15:0];
            span_q              <= span_now;
        end
        if (cmd.tick_clear)
        begin
            box_mask_q <= bit_mask;
        end
        if (cmd.take_lo)
        begin
            lo_q <= sat16(quot_w - $signed({9'b0, span_q[11:1]}));
        end
        if (cmd.take_hi)
        begin
            hi_q <= sat16(quot_w - $signed({9'b0, span_q[11:1]}));
        end
        index_reg <= cmd.servo_idx;
        pulse_reg <= pulse_next;
        last_reg  <= cmd.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rout_vld_reg <= '0;
            strobe_reg   <= 1'b0;
            for (int i = 0; i < SOURCES; i++)
            begin
                src_reg[i] <= '0;
            end
            for (int i = 0; i < SERVOS; i++)
            begin
                sum_reg[i] <= '0;
            end
        end
        else
        begin
            strobe_reg <= cmd.servo_emit;
            if (accept && (command == CMD_SOURCE) && (idx_ext < 7'(SOURCES)))
            begin
                src_reg[idx_ext[CW-1:0]] <= value;
            end
            if (cmd.rule_eval)
            begin
                rout_vld_reg[rule_addr] <= 1'b1;
            end
            if (cmd.tick_clear)
            begin
                for (int i = 0; i < SERVOS; i++)
                begin
                    sum_reg[i] <= '0;
                end
            end
            else if (cmd.rule_add)
            begin
                sum_reg[servo_addr] <= sum_new;
            end
        end
    end

    assign strobe      = strobe_reg;
    assign servo_index = index_reg;
    assign servo_pulse = pulse_reg;
    assign last        = last_reg;

endmodule
`default_nettype wire
